// ===== rtl/rcl_pkg.sv =====
// shared constants and types for the relative compactor level
package rcl_pkg;

  localparam int SECTION_SIZE_DEF = 16;
  localparam int NUM_SECTIONS_DEF = 8;
  localparam int KEY_BITS_DEF     = 64;
  localparam int FIELD_W          = 64;

  // control from the sequencer to the running-maximum unit
  typedef struct packed {
    logic vld;
    logic first;
  } cmp_ctrl_t;

endpackage

// ===== rtl/rcl_ram.sv =====
// generic single write port, single read port ram with registered read
module rcl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rcl_max.sv =====
// running maximum of a key stream with the address where it was seen
module rcl_max #(
  parameter int KEY_BITS = 64,
  parameter int AW       = 8
) (
  input  logic                 clk,
  input  rcl_pkg::cmp_ctrl_t   ctrl,
  input  logic [KEY_BITS-1:0]  data,
  input  logic [AW-1:0]        idx,
  output logic [KEY_BITS-1:0]  max_key,
  output logic [AW-1:0]        max_idx
);
  import rcl_pkg::*;

  logic bigger;

  assign bigger = data > max_key;

  always_ff @(posedge clk) begin
    if (ctrl.vld && (ctrl.first || bigger)) begin
      max_key <= data;
      max_idx <= idx;
    end
  end

endmodule

// ===== rtl/relative_compactor_level.sv =====
// top level of one relative-error quantile sketch compactor level
//
// usage:
//  - input channel s_*: one transfer per key, with the coin bit on s_tuser
//  - output channel m_*: promoted keys in ascending order, m_tlast on the
//    final key of a compaction
//  - while the buffer is not full a key is written straight to the ram and
//    s_tready stays high, so keys can follow one per cycle
//  - when the buffer holds CAP keys the next key triggers a compaction: a
//    repeated selection scan over the key ram with one shared comparator
//    places the largest amount = sections*SECTION_SIZE keys at the top in
//    ascending order; each pass scans addresses 0 to top through the
//    single read port of the ram and then swaps the maximum into top;
//    every second sorted key, from start plus the coin bit, is promoted
//  - s_tready is low for the whole compaction; results wait in the output
//    register while m_tready is low and the sequencer waits with them
//  - reset clears the fill count and the schedule counter; the key ram is
//    not cleared since only entries below the fill count are ever read
module relative_compactor_level #(
  parameter int SECTION_SIZE = rcl_pkg::SECTION_SIZE_DEF,
  parameter int NUM_SECTIONS = rcl_pkg::NUM_SECTIONS_DEF,
  parameter int KEY_BITS     = rcl_pkg::KEY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [rcl_pkg::FIELD_W-1:0] s_tdata,  // key
  input  logic [0:0]                s_tuser,    // coin
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rcl_pkg::FIELD_W-1:0] m_tdata,  // out_key
  output logic                      m_tlast     // last
);
  import rcl_pkg::*;

  localparam int CAP = 2 * SECTION_SIZE * NUM_SECTIONS;
  localparam int AW  = $clog2(CAP);
  localparam int FW  = $clog2(CAP + 1);
  localparam int SW  = $clog2(NUM_SECTIONS + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_SWRD = 4'd2;
  localparam logic [3:0] S_SWWT = 4'd3;
  localparam logic [3:0] S_SWA  = 4'd4;
  localparam logic [3:0] S_ERD  = 4'd5;
  localparam logic [3:0] S_EWT  = 4'd6;
  localparam logic [3:0] S_EOUT = 4'd7;
  localparam logic [3:0] S_APP  = 4'd8;

  logic [3:0]          state;
  logic [FW-1:0]       fill;
  logic [63:0]         sched;
  logic [KEY_BITS-1:0] key;
  logic                coin;
  logic [AW-1:0]       start;
  logic [AW-1:0]       top;
  logic [AW-1:0]       scan_addr;
  logic [FW-1:0]       e_addr;

  // scan pipeline, aligned with the registered ram read
  cmp_ctrl_t           cmp;
  logic [AW-1:0]       cmp_idx;

  logic [KEY_BITS-1:0] max_key;
  logic [AW-1:0]       max_idx;

  // ram ports
  logic                we;
  logic [AW-1:0]       waddr;
  logic [KEY_BITS-1:0] wdata;
  logic                re;
  logic [AW-1:0]       raddr;
  logic [KEY_BITS-1:0] rdata;

  logic                accept;
  logic                full;
  logic [SW-1:0]       sections;
  logic [AW:0]         amount;
  logic [AW:0]         start_next;
  logic [FW:0]         e_step;

  assign accept = s_tvalid && s_tready;
  assign full   = fill == FW'(CAP);
  assign s_tready = state == S_IDLE;

  // trailing ones plus one, capped at the number of sections
  always_comb begin
    logic run;
    run      = 1'b1;
    sections = SW'(1);
    for (int i = 0; i < NUM_SECTIONS - 1; i++) begin
      run = run && sched[i];
      if (run) begin
        sections = SW'(i + 2);
      end
    end
  end

  assign amount     = (AW + 1)'(sections) * (AW + 1)'(SECTION_SIZE);
  assign start_next = (AW + 1)'(CAP) - amount;
  assign e_step     = (FW + 1)'(e_addr) + (FW + 1)'(2);

  // ram access selection
  always_comb begin
    we    = 1'b0;
    waddr = fill[AW-1:0];
    wdata = s_tdata[KEY_BITS-1:0];
    re    = 1'b0;
    raddr = scan_addr;
    case (state)
      S_IDLE: begin
        we = accept && !full;
      end
      S_SCAN: begin
        re = 1'b1;
      end
      S_SWRD: begin
        re    = 1'b1;
        raddr = top;
      end
      S_SWWT: begin
        we    = 1'b1;
        waddr = top;
        wdata = max_key;
      end
      S_SWA: begin
        we    = 1'b1;
        waddr = max_idx;
        wdata = rdata;
      end
      S_ERD: begin
        re    = 1'b1;
        raddr = e_addr[AW-1:0];
      end
      S_APP: begin
        we    = 1'b1;
        waddr = start;
        wdata = key;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  rcl_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAP)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  rcl_max #(
    .KEY_BITS (KEY_BITS),
    .AW       (AW)
  ) u_max (
    .clk     (clk),
    .ctrl    (cmp),
    .data    (rdata),
    .idx     (cmp_idx),
    .max_key (max_key),
    .max_idx (max_idx)
  );

  // scan pipeline follows the read issued in the scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp.vld   <= 1'b0;
      cmp.first <= 1'b0;
    end else begin
      cmp.vld   <= state == S_SCAN;
      cmp.first <= scan_addr == '0;
    end
    cmp_idx <= scan_addr;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      sched    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            key  <= s_tdata[KEY_BITS-1:0];
            coin <= s_tuser[0];
            if (full) begin
              start     <= start_next[AW-1:0];
              top       <= AW'(CAP - 1);
              scan_addr <= '0;
              state     <= S_SCAN;
            end else begin
              fill <= fill + FW'(1);
            end
          end
        end
        S_SCAN: begin
          if (scan_addr == top) begin
            state <= S_SWRD;
          end else begin
            scan_addr <= scan_addr + AW'(1);
          end
        end
        S_SWRD: begin
          state <= S_SWWT;
        end
        S_SWWT: begin
          state <= S_SWA;
        end
        S_SWA: begin
          if (top == start) begin
            e_addr <= FW'(start) + FW'(coin);
            state  <= S_ERD;
          end else begin
            top       <= top - AW'(1);
            scan_addr <= '0;
            state     <= S_SCAN;
          end
        end
        S_ERD: begin
          state <= S_EWT;
        end
        S_EWT: begin
          m_tdata  <= FIELD_W'(rdata);
          m_tlast  <= e_step >= (FW + 1)'(CAP);
          m_tvalid <= 1'b1;
          state    <= S_EOUT;
        end
        S_EOUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= S_APP;
            end else begin
              e_addr <= e_step[FW-1:0];
              state  <= S_ERD;
            end
          end
        end
        S_APP: begin
          fill  <= FW'(start) + FW'(1);
          sched <= sched + 64'd1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("output valid while idle");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(CAP))
    else $error("fill count beyond capacity");

  a_plain_insert: assert property (@(posedge clk) disable iff (rst)
    (accept && !full) |=> fill == $past(fill) + FW'(1))
    else $error("plain insert did not advance fill count");

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (top >= start && scan_addr <= top))
    else $error("selection scan out of range");
`endif

endmodule
